@@ rtl/assert_macros.svh @@
// Assertion macros shared by the differential position PID RTL.
// Included by the modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

@@ rtl/dpp_pkg.sv @@
// Package for the differential position PID: opcodes, register indexes,
// fixed-point constants and the error stage record. No dependencies.
package dpp_pkg;

  localparam int unsigned DiffW   = 16;
  localparam int unsigned SumW    = 32;
  localparam int unsigned DeltaW  = DiffW + 1;
  localparam int unsigned GainW   = 32;
  localparam int unsigned DutyW   = 17;
  localparam int unsigned CorrW   = 64;
  localparam int unsigned FracW   = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [DutyW-1:0] DutyOne = DutyW'(65536);
  localparam logic [DutyW-1:0] BaseDutyReset = DutyW'(32768);

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_P    = 2'd0,
    CFG_GAIN_I    = 2'd1,
    CFG_GAIN_D    = 2'd2,
    CFG_BASE_DUTY = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [DiffW-1:0]  diff;
    logic signed [SumW-1:0]   sum;
    logic signed [DeltaW-1:0] delta;
  } err_stage_t;

  typedef struct packed {
    logic signed [GainW-1:0] kp;
    logic signed [GainW-1:0] ki;
    logic signed [GainW-1:0] kd;
  } gains_t;

endpackage

@@ rtl/dpp_err.sv @@
// Error stage: saturating error sum, previous difference and the input register.
// Depends on dpp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dpp_err import dpp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  op_e                     opcode_i,
  input  logic signed [DiffW-1:0] diff_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output err_stage_t              out_o
);

  logic                    valid_q, valid_d;
  logic signed [SumW-1:0]  err_sum_q, err_sum_d;
  logic signed [DiffW-1:0] last_diff_q, last_diff_d;
  err_stage_t              stage_q, stage_d;
  logic signed [SumW:0]    sum_wide;
  logic signed [SumW-1:0]  sum_sat;
  logic                    accept;
  logic                    update;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign update     = accept && (opcode_i == OP_UPDATE);

  always_comb begin
    sum_wide = {err_sum_q[SumW-1], err_sum_q} + (SumW+1)'(diff_i);
    if (sum_wide[SumW] != sum_wide[SumW-1]) begin
      sum_sat = sum_wide[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SumW-1:0];
    end
  end

  always_comb begin
    valid_d     = valid_q;
    err_sum_d   = err_sum_q;
    last_diff_d = last_diff_q;
    stage_d     = stage_q;
    if (in_ready_o) begin
      valid_d = update;
    end
    if (accept) begin
      if (opcode_i == OP_CLEAR) begin
        err_sum_d   = '0;
        last_diff_d = '0;
      end else begin
        err_sum_d     = sum_sat;
        last_diff_d   = diff_i;
        stage_d.diff  = diff_i;
        stage_d.sum   = sum_sat;
        stage_d.delta = DeltaW'(diff_i) - DeltaW'(last_diff_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      err_sum_q   <= '0;
      last_diff_q <= '0;
    end else begin
      valid_q     <= valid_d;
      err_sum_q   <= err_sum_d;
      last_diff_q <= last_diff_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign out_valid_o = valid_q;
  assign out_o       = stage_q;

  `ASSERT_PROP(a_clear_zeroes, clk_i, rst_ni,
    accept && (opcode_i == OP_CLEAR) |=> (err_sum_q == '0) && (last_diff_q == '0),
    "error state not cleared by clear opcode")
  `ASSERT_PROP(a_clear_no_result, clk_i, rst_ni,
    accept && (opcode_i == OP_CLEAR) |=> !valid_q, "clear opcode produced a result")

endmodule

@@ rtl/dpp_corr.sv @@
// Correction stages: three gain products registered, then their 64-bit wrapping sum.
// Depends on dpp_pkg.
module dpp_corr import dpp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  gains_t                  gains_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  err_stage_t              in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [CorrW-1:0] corr_o
);

  logic                                valid_mul_q;
  logic                                valid_sum_q;
  logic                                en_mul;
  logic                                en_sum;
  logic signed [GainW+DiffW-1:0]       prod_p_q;
  logic signed [GainW+SumW-1:0]        prod_i_q;
  logic signed [GainW+DeltaW-1:0]      prod_d_q;
  logic signed [CorrW-1:0]             corr_q;

  assign en_sum     = !valid_sum_q || out_ready_i;
  assign en_mul     = !valid_mul_q || en_sum;
  assign in_ready_o = en_mul;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_mul_q <= 1'b0;
      valid_sum_q <= 1'b0;
    end else begin
      if (en_mul) begin
        valid_mul_q <= in_valid_i;
      end
      if (en_sum) begin
        valid_sum_q <= valid_mul_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_mul && in_valid_i) begin
      prod_p_q <= gains_i.kp * in_i.diff;
      prod_i_q <= gains_i.ki * in_i.sum;
      prod_d_q <= gains_i.kd * in_i.delta;
    end
    if (en_sum && valid_mul_q) begin
      corr_q <= CorrW'(prod_p_q) + CorrW'(prod_i_q) + CorrW'(prod_d_q);
    end
  end

  assign out_valid_o = valid_sum_q;
  assign corr_o      = corr_q;

endmodule

@@ rtl/dpp_duty.sv @@
// Duty stage: splits the correction onto the two motors, clamps, and holds the result.
// Depends on dpp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dpp_duty import dpp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [DutyW-1:0]        base_duty_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [CorrW-1:0] corr_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [DutyW-1:0]        duty_one_o,
  output logic [DutyW-1:0]        duty_two_o
);

  logic                     valid_q;
  logic [DutyW-1:0]         duty_one_q, duty_one_d;
  logic [DutyW-1:0]         duty_two_q, duty_two_d;
  logic                     neg;
  logic [CorrW-1:0]         mag;
  logic [CorrW-FracW-1:0]   raise;
  logic [DutyW:0]           raise_c;
  logic [DutyW+1:0]         raised;
  logic [DutyW-1:0]         raised_c;
  logic [DutyW-1:0]         base_c;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    neg      = corr_i[CorrW-1];
    mag      = neg ? (CorrW'(0) - $unsigned(corr_i)) : $unsigned(corr_i);
    raise    = mag[CorrW-1:FracW];
    raise_c  = (raise > (CorrW-FracW)'(DutyOne)) ? ((DutyW+1)'(DutyOne) + (DutyW+1)'(1))
                                                 : raise[DutyW:0];
    raised   = (DutyW+2)'(base_duty_i) + (DutyW+2)'(raise_c);
    raised_c = (raised > (DutyW+2)'(DutyOne)) ? DutyOne : raised[DutyW-1:0];
    base_c   = (base_duty_i > DutyOne) ? DutyOne : base_duty_i;
    duty_one_d = neg ? raised_c : base_c;
    duty_two_d = neg ? base_c : raised_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      duty_one_q <= duty_one_d;
      duty_two_q <= duty_two_d;
    end
  end

  assign out_valid_o = valid_q;
  assign duty_one_o  = duty_one_q;
  assign duty_two_o  = duty_two_q;

  `ASSERT_NEVER(a_duty_range, clk_i, rst_ni,
    valid_q && ((duty_one_q > DutyOne) || (duty_two_q > DutyOne)),
    "duty above full scale")
  `ASSERT_NEVER(a_one_side_raised, clk_i, rst_ni,
    valid_q && (duty_one_q != base_c) && (duty_two_q != base_c),
    "both duties raised")

endmodule

@@ rtl/differential_position_pid.sv @@
// Top level of the differential position PID: configuration registers and the
// four-stage pipeline. Depends on dpp_pkg, dpp_err, dpp_corr and dpp_duty.
//
// One update word enters per clock cycle unless the output stalls, and its duty
// word passes through the error stage, the registered gain multipliers, the
// 64-bit correction sum and the clamped duty register in turn. A clear
// word zeroes the error sum and the previous difference and yields no output
// word. Each stage holds its word while the output is stalled, and an empty
// stage keeps accepting. Configuration is written through a plain write port
// and should only change while the pipeline is empty.
module differential_position_pid import dpp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [GainW-1:0]     cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [15:0] position_difference
  input  logic [15:0]          s_axis_tdata,
  // [0] opcode
  input  logic [0:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [16:0] duty_motor_one, [33:17] duty_motor_two, [39:34] zero
  output logic [39:0]          m_axis_tdata
);

  gains_t                  gains_q;
  logic [DutyW-1:0]        base_duty_q;
  err_stage_t              err_stage;
  logic                    err_valid;
  logic                    corr_ready;
  logic                    corr_valid;
  logic                    duty_ready;
  logic signed [CorrW-1:0] corr;
  logic [DutyW-1:0]        duty_one;
  logic [DutyW-1:0]        duty_two;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q     <= '0;
      base_duty_q <= BaseDutyReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN_P:    gains_q.kp  <= cfg_data_i;
        CFG_GAIN_I:    gains_q.ki  <= cfg_data_i;
        CFG_GAIN_D:    gains_q.kd  <= cfg_data_i;
        CFG_BASE_DUTY: base_duty_q <= cfg_data_i[DutyW-1:0];
        default: ;
      endcase
    end
  end

  dpp_err u_err (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .opcode_i    (op_e'(s_axis_tuser[0])),
    .diff_i      (s_axis_tdata[DiffW-1:0]),
    .out_valid_o (err_valid),
    .out_ready_i (corr_ready),
    .out_o       (err_stage)
  );

  dpp_corr u_corr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .gains_i     (gains_q),
    .in_valid_i  (err_valid),
    .in_ready_o  (corr_ready),
    .in_i        (err_stage),
    .out_valid_o (corr_valid),
    .out_ready_i (duty_ready),
    .corr_o      (corr)
  );

  dpp_duty u_duty (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .base_duty_i (base_duty_q),
    .in_valid_i  (corr_valid),
    .in_ready_o  (duty_ready),
    .corr_i      (corr),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .duty_one_o  (duty_one),
    .duty_two_o  (duty_two)
  );

  assign m_axis_tdata = {6'b0, duty_two, duty_one};

endmodule
